// ===== hdl/hrvm_pkg.sv =====
// Shared types and constants for the HRV LED brightness modulator.
// Used by the serial arithmetic units, the top level and the checker.
// No dependencies.
package hrvm_pkg;

  // Field widths
  localparam int TIME_W = 32;
  localparam int HRV_W  = 16;
  localparam int LVL_W  = 8;
  localparam int CFG_W  = 16;
  localparam int CFG_AW = 3;

  // Stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((TIME_W + HRV_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * LVL_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_UPDATE_INTERVAL = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CHANGE_THRESH   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_LEVEL       = 3'd2;
  localparam logic [CFG_AW-1:0] REG_BASE_LEVEL      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CENTER_GAIN     = 3'd4;

  // Averaging window
  localparam int WIN_DEPTH = 8;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int SUM_W     = HRV_W + WIN_AW;

  // Serial multiplier: multiplicand up to the window sum, multiplier 16 bits
  localparam int MUL_A_W = SUM_W;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int MUL_CW  = $clog2(MUL_B_W + 1);

  // Serial divider: 16-bit quotient, 16-bit divisor
  localparam int DIV_W  = 16;
  localparam int DIV_CW = $clog2(DIV_W + 1);

  // Fixed-point constants
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 12;
  localparam int CG_FRAC   = 6;
  localparam int HRV_FRAC  = 4;
  localparam int THR_FRAC  = 16;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd4096;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 16'hFFFF;
  localparam logic [TIME_W-1:0] REFRESH_MS = 32'd20;
  localparam logic [HRV_W-HRV_FRAC-1:0] HRV_LOW_MS  = 12'd20;
  localparam logic [HRV_W-HRV_FRAC-1:0] HRV_HIGH_MS = 12'd200;
  localparam logic [DIV_W-1:0] LEVEL_SPAN = 16'd180;
  localparam logic [LVL_W-1:0] LVL_FULL   = 8'd255;

  // Start request for the serial multiplier
  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  // Start request for the serial divider
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] rem_init;
    logic [DIV_W-1:0] dividend_lo;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== hdl/hrv_led_brightness_modulator.sv =====
// Top level of the HRV LED brightness modulator: sequencer, window store and output register.
// Depends on hrvm_pkg, hrvm_mul_serial and hrvm_div_serial.
//
// Each input transaction carries a millisecond timestamp and an HRV sample (Q12.4 ms).
// A sample is taken into an eight-entry averaging window when more than update_interval_ms
// has passed since the last one taken; if it strays from the window average by more than
// change_threshold, the gain becomes the ratio of this sample to the previous one. At most
// one output transaction follows per input, and only once 20 ms have passed since the last
// refresh; it carries the ring and centre LED levels. All products go through one
// bit-serial multiplier and all quotients through one bit-serial divider. An input holds
// in_tready low while it is worked: through the deviation test when the sample is taken,
// the gain division when the gain is recomputed, and the level multiply, level divide,
// gain multiply, centre multiply and output handoff when a refresh is due.
// A finished result waits in the output register while the next transaction is taken.
module hrv_led_brightness_modulator (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port
  input  logic                              cfg_wr_en,
  input  logic [hrvm_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [hrvm_pkg::CFG_W-1:0]        cfg_wdata,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata: [31:0] time_ms, [47:32] hrv
  input  logic [hrvm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Output stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: [7:0] ring_level, [15:8] center_level
  output logic [hrvm_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE = 4'd0;
  localparam logic [ST_W-1:0] S_EVAL = 4'd1;
  localparam logic [ST_W-1:0] S_THR  = 4'd2;
  localparam logic [ST_W-1:0] S_GDIV = 4'd3;
  localparam logic [ST_W-1:0] S_GEND = 4'd4;
  localparam logic [ST_W-1:0] S_LMUL = 4'd5;
  localparam logic [ST_W-1:0] S_LDIV = 4'd6;
  localparam logic [ST_W-1:0] S_GMUL = 4'd7;
  localparam logic [ST_W-1:0] S_CMUL = 4'd8;
  localparam logic [ST_W-1:0] S_OUT  = 4'd9;

  localparam int MS_W = hrvm_pkg::HRV_W - hrvm_pkg::HRV_FRAC;
  localparam int G_W  = hrvm_pkg::LVL_W + hrvm_pkg::GAIN_W - hrvm_pkg::GAIN_FRAC;
  localparam int C_W  = 2 * hrvm_pkg::LVL_W - hrvm_pkg::CG_FRAC;

  // Configuration registers
  logic [15:0] interval_r;
  logic [15:0] thr_r;
  logic [hrvm_pkg::LVL_W-1:0] max_r;
  logic [hrvm_pkg::LVL_W-1:0] base_r;
  logic [hrvm_pkg::LVL_W-1:0] cg_r;

  // Sequencer and block state
  logic [ST_W-1:0] state_r;
  logic [ST_W-1:0] state_nxt;
  logic [hrvm_pkg::TIME_W-1:0] t_r;
  logic [hrvm_pkg::HRV_W-1:0]  h_r;
  logic [hrvm_pkg::HRV_W-1:0]  win_r [hrvm_pkg::WIN_DEPTH];
  logic [hrvm_pkg::WIN_AW-1:0] slot_r;
  logic [hrvm_pkg::SUM_W-1:0]  sum_r;
  logic [hrvm_pkg::HRV_W-1:0]  prev_r;
  logic [hrvm_pkg::GAIN_W-1:0] gain_r;
  logic [hrvm_pkg::TIME_W-1:0] last_smp_r;
  logic [hrvm_pkg::TIME_W-1:0] last_rfsh_r;
  logic                        take_r;
  logic                        rfsh_r;
  logic [hrvm_pkg::LVL_W-1:0]  g_r;
  logic                        out_valid_r;
  logic [hrvm_pkg::LVL_W-1:0]  ring_r;
  logic [hrvm_pkg::LVL_W-1:0]  center_r;

  // Arithmetic unit handshakes
  hrvm_pkg::mul_req_t          mreq;
  hrvm_pkg::div_req_t          dreq;
  logic                        mul_done;
  logic [hrvm_pkg::MUL_P_W-1:0] mul_prod;
  logic                        div_done;
  logic [hrvm_pkg::DIV_W-1:0]  div_q;

  // Datapath helpers
  logic [hrvm_pkg::TIME_W-1:0] smp_elapsed;
  logic [hrvm_pkg::TIME_W-1:0] rfsh_elapsed;
  logic                        take_w;
  logic                        rfsh_w;
  logic [hrvm_pkg::SUM_W-1:0]  sum_upd;
  logic [hrvm_pkg::SUM_W-1:0]  scaled;
  logic [hrvm_pkg::SUM_W-1:0]  dev;
  logic                        signif;
  logic                        gain_sat;
  logic [MS_W-1:0]             ms;
  logic [MS_W-1:0]             ms_cl;
  logic [hrvm_pkg::LVL_W-1:0]  ms_off;
  logic                        lvl_neg;
  logic [hrvm_pkg::LVL_W-1:0]  lvl_mag;
  logic [hrvm_pkg::LVL_W-1:0]  b_w;
  logic [G_W-1:0]              g_full;
  logic [hrvm_pkg::LVL_W-1:0]  g_w;
  logic [C_W-1:0]              c_full;
  logic [hrvm_pkg::LVL_W-1:0]  c_w;
  logic                        out_free;

  hrvm_mul_serial u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .done (mul_done),
    .prod (mul_prod)
  );

  hrvm_div_serial u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .done (div_done),
    .quot (div_q)
  );

  // Timing tests, window update and deviation test.
  always_comb begin
    smp_elapsed  = t_r - last_smp_r;
    rfsh_elapsed = t_r - last_rfsh_r;
    take_w       = smp_elapsed > {16'd0, interval_r};
    rfsh_w       = rfsh_elapsed >= hrvm_pkg::REFRESH_MS;
    sum_upd      = sum_r - hrvm_pkg::SUM_W'(win_r[slot_r]) + hrvm_pkg::SUM_W'(h_r);
    scaled       = hrvm_pkg::SUM_W'(hrvm_pkg::SUM_W'(h_r) *
                                    hrvm_pkg::SUM_W'(hrvm_pkg::WIN_DEPTH));
    dev          = (scaled > sum_r) ? (scaled - sum_r) : (sum_r - scaled);
    signif       = ({dev, {hrvm_pkg::THR_FRAC{1'b0}}} > mul_prod) && (prev_r != '0);
    gain_sat     = {{hrvm_pkg::HRV_FRAC{1'b0}}, h_r} >= {prev_r, {hrvm_pkg::HRV_FRAC{1'b0}}};
  end

  // Level map, gain clamp and centre scaling.
  always_comb begin
    ms = h_r[hrvm_pkg::HRV_W-1:hrvm_pkg::HRV_FRAC];
    if (ms < hrvm_pkg::HRV_LOW_MS) begin
      ms_cl = hrvm_pkg::HRV_LOW_MS;
    end else if (ms > hrvm_pkg::HRV_HIGH_MS) begin
      ms_cl = hrvm_pkg::HRV_HIGH_MS;
    end else begin
      ms_cl = ms;
    end
    ms_off  = hrvm_pkg::LVL_W'(ms_cl - hrvm_pkg::HRV_LOW_MS);
    lvl_neg = base_r < max_r;
    lvl_mag = lvl_neg ? (max_r - base_r) : (base_r - max_r);
    b_w     = lvl_neg ? (max_r - div_q[hrvm_pkg::LVL_W-1:0])
                      : (max_r + div_q[hrvm_pkg::LVL_W-1:0]);
    g_full  = mul_prod[hrvm_pkg::GAIN_FRAC+G_W-1:hrvm_pkg::GAIN_FRAC];
    if (g_full < G_W'(base_r)) begin
      g_w = base_r;
    end else if (g_full > G_W'(max_r)) begin
      g_w = max_r;
    end else begin
      g_w = g_full[hrvm_pkg::LVL_W-1:0];
    end
    c_full  = mul_prod[hrvm_pkg::CG_FRAC+C_W-1:hrvm_pkg::CG_FRAC];
    c_w     = (c_full > C_W'(hrvm_pkg::LVL_FULL)) ? hrvm_pkg::LVL_FULL
                                                  : c_full[hrvm_pkg::LVL_W-1:0];
    out_free = !out_valid_r || out_tready;
  end

  // Sequencer: next state and start requests to the shared units.
  always_comb begin
    state_nxt = state_r;
    mreq      = '0;
    dreq      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (take_w && (sum_upd != '0)) begin
          mreq.start = 1'b1;
          mreq.a     = sum_upd;
          mreq.b     = thr_r;
          state_nxt  = S_THR;
        end else begin
          state_nxt = S_GEND;
        end
      end
      S_THR: begin
        if (mul_done) begin
          if (signif && !gain_sat) begin
            dreq.start       = 1'b1;
            dreq.rem_init    = hrvm_pkg::DIV_W'(h_r >> (hrvm_pkg::DIV_W - hrvm_pkg::GAIN_FRAC));
            dreq.dividend_lo = hrvm_pkg::DIV_W'(h_r << hrvm_pkg::GAIN_FRAC);
            dreq.divisor     = prev_r;
            state_nxt        = S_GDIV;
          end else begin
            state_nxt = S_GEND;
          end
        end
      end
      S_GDIV: begin
        if (div_done) begin
          state_nxt = S_GEND;
        end
      end
      S_GEND: begin
        if (rfsh_r) begin
          mreq.start = 1'b1;
          mreq.a     = hrvm_pkg::MUL_A_W'(ms_off);
          mreq.b     = hrvm_pkg::MUL_B_W'(lvl_mag);
          state_nxt  = S_LMUL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LMUL: begin
        if (mul_done) begin
          dreq.start       = 1'b1;
          dreq.rem_init    = '0;
          dreq.dividend_lo = hrvm_pkg::DIV_W'(mul_prod);
          dreq.divisor     = hrvm_pkg::LEVEL_SPAN;
          state_nxt        = S_LDIV;
        end
      end
      S_LDIV: begin
        if (div_done) begin
          mreq.start = 1'b1;
          mreq.a     = hrvm_pkg::MUL_A_W'(b_w);
          mreq.b     = gain_r;
          state_nxt  = S_GMUL;
        end
      end
      S_GMUL: begin
        if (mul_done) begin
          mreq.start = 1'b1;
          mreq.a     = hrvm_pkg::MUL_A_W'(g_w);
          mreq.b     = hrvm_pkg::MUL_B_W'(cg_r);
          state_nxt  = S_CMUL;
        end
      end
      S_CMUL: begin
        if (mul_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, configuration, window and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      interval_r  <= 16'd1000;
      thr_r       <= 16'd6554;
      max_r       <= 8'd255;
      base_r      <= 8'd10;
      cg_r        <= 8'd96;
      for (int i = 0; i < hrvm_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
      slot_r      <= '0;
      sum_r       <= '0;
      prev_r      <= '0;
      gain_r      <= hrvm_pkg::GAIN_ONE;
      last_smp_r  <= '0;
      last_rfsh_r <= '0;
      take_r      <= 1'b0;
      rfsh_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes
      if (cfg_wr_en) begin
        case (cfg_addr)
          hrvm_pkg::REG_UPDATE_INTERVAL: interval_r <= cfg_wdata;
          hrvm_pkg::REG_CHANGE_THRESH:   thr_r      <= cfg_wdata;
          hrvm_pkg::REG_MAX_LEVEL:       max_r      <= cfg_wdata[hrvm_pkg::LVL_W-1:0];
          hrvm_pkg::REG_BASE_LEVEL:      base_r     <= cfg_wdata[hrvm_pkg::LVL_W-1:0];
          hrvm_pkg::REG_CENTER_GAIN:     cg_r       <= cfg_wdata[hrvm_pkg::LVL_W-1:0];
          default: ;
        endcase
      end

      // Sample acceptance and refresh decision
      if (state_r == S_EVAL) begin
        take_r <= take_w;
        rfsh_r <= rfsh_w;
        if (take_w) begin
          win_r[slot_r] <= h_r;
          sum_r         <= sum_upd;
          slot_r        <= (slot_r == hrvm_pkg::WIN_AW'(hrvm_pkg::WIN_DEPTH - 1)) ?
                           '0 : slot_r + 1'b1;
          last_smp_r    <= t_r;
        end
        if (rfsh_w) begin
          last_rfsh_r <= t_r;
        end
      end

      // Gain update
      if ((state_r == S_THR) && mul_done && signif && gain_sat) begin
        gain_r <= hrvm_pkg::GAIN_MAX;
      end
      if ((state_r == S_GDIV) && div_done) begin
        gain_r <= div_q;
      end
      if ((state_r == S_GEND) && take_r) begin
        prev_r <= h_r;
      end

      // Output register: a new result takes the slot that a taken one frees.
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_tvalid) begin
      t_r <= in_tdata[hrvm_pkg::TIME_W-1:0];
      h_r <= in_tdata[hrvm_pkg::TIME_W+hrvm_pkg::HRV_W-1:hrvm_pkg::TIME_W];
    end
    if ((state_r == S_GMUL) && mul_done) begin
      g_r <= g_w;
    end
    if ((state_r == S_OUT) && out_free) begin
      ring_r   <= g_r;
      center_r <= c_w;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {center_r, ring_r};

endmodule

// ===== hdl/hrvm_mul_serial.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on hrvm_pkg for widths and the request struct.
module hrvm_mul_serial (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hrvm_pkg::mul_req_t         req,
  output logic                       done,
  output logic [hrvm_pkg::MUL_P_W-1:0] prod
);

  logic [hrvm_pkg::MUL_A_W-1:0] a_r;
  logic [hrvm_pkg::MUL_P_W:0]   p_r;
  logic [hrvm_pkg::MUL_P_W:0]   p_nxt;
  logic [hrvm_pkg::MUL_CW-1:0]  cnt_r;
  logic                         done_r;
  logic [hrvm_pkg::MUL_A_W:0]   hi_sum;

  // Add the multiplicand into the upper half when the low bit is set, then shift right.
  always_comb begin
    hi_sum = p_r[hrvm_pkg::MUL_P_W:hrvm_pkg::MUL_B_W] +
             (p_r[0] ? {1'b0, a_r} : '0);
    p_nxt  = {1'b0, hi_sum, p_r[hrvm_pkg::MUL_B_W-1:1]};
  end

  // Iteration count and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= hrvm_pkg::MUL_CW'(hrvm_pkg::MUL_B_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == hrvm_pkg::MUL_CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial product shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      p_r <= {{(hrvm_pkg::MUL_A_W + 1){1'b0}}, req.b};
    end else if (cnt_r != '0) begin
      p_r <= p_nxt;
    end
  end

  assign done = done_r;
  assign prod = p_r[hrvm_pkg::MUL_P_W-1:0];

endmodule

// ===== hdl/hrvm_div_serial.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on hrvm_pkg for widths and the request struct.
module hrvm_div_serial (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hrvm_pkg::div_req_t       req,
  output logic                     done,
  output logic [hrvm_pkg::DIV_W-1:0] quot
);

  logic [hrvm_pkg::DIV_W-1:0]  rem_r;
  logic [hrvm_pkg::DIV_W-1:0]  quo_r;
  logic [hrvm_pkg::DIV_W-1:0]  dvs_r;
  logic [hrvm_pkg::DIV_CW-1:0] cnt_r;
  logic                        done_r;
  logic [hrvm_pkg::DIV_W:0]    trial;
  logic [hrvm_pkg::DIV_W+1:0]  diff;
  logic                        fits;
  logic [hrvm_pkg::DIV_W-1:0]  rem_nxt;
  logic [hrvm_pkg::DIV_W-1:0]  quo_nxt;

  // Bring down the next dividend bit and try to subtract the divisor.
  // The dividend bits leave the top of quo_r while quotient bits enter at the bottom.
  always_comb begin
    trial   = {rem_r, quo_r[hrvm_pkg::DIV_W-1]};
    diff    = {1'b0, trial} - {2'b00, dvs_r};
    fits    = !diff[hrvm_pkg::DIV_W+1];
    rem_nxt = fits ? diff[hrvm_pkg::DIV_W-1:0] : trial[hrvm_pkg::DIV_W-1:0];
    quo_nxt = {quo_r[hrvm_pkg::DIV_W-2:0], fits};
  end

  // Iteration count and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= hrvm_pkg::DIV_CW'(hrvm_pkg::DIV_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == hrvm_pkg::DIV_CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      quo_r <= req.dividend_lo;
      dvs_r <= req.divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== hdl/hrvm_checker.sv =====
// Port-level checker for the HRV LED brightness modulator, bound to the top level.
// Depends on hrvm_pkg for port widths.
module hrvm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              cfg_wr_en,
  input logic [hrvm_pkg::CFG_AW-1:0]       cfg_addr,
  input logic [hrvm_pkg::CFG_W-1:0]        cfg_wdata,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [hrvm_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [hrvm_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // A stalled result keeps its levels.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // One transaction is worked at a time: the port closes right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while an item is in work");

  // A result never appears in the cycle right after an input transaction.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result appeared too early");

endmodule

bind hrv_led_brightness_modulator hrvm_checker u_hrvm_checker (.*);

// ===== tb/hrvm_level_checker.sv =====
`timescale 1ns / 1ps
// Checker for the HRV LED brightness modulator: follows the configuration writes and the input
// stream, predicts the ring and centre levels, and compares them with the output stream.
// Depends on hrvm_pkg.
module hrvm_level_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [hrvm_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [hrvm_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  // in_tdata: [31:0] time_ms, [47:32] hrv
  input  logic [hrvm_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: [7:0] ring_level, [15:8] center_level
  input  logic [hrvm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output int                                fail_count,
  output int                                pending
);
  import hrvm_pkg::*;

  // Ring level in the low byte, as on out_tdata.
  typedef struct packed {
    logic [LVL_W-1:0] center;
    logic [LVL_W-1:0] ring;
  } levels_t;

  // Shadow of the configuration registers.
  logic [15:0]      interval_ms;
  logic [15:0]      threshold;
  logic [LVL_W-1:0] top_level;
  logic [LVL_W-1:0] floor_level;
  logic [LVL_W-1:0] centre_mult;

  // Shadow of the modulator state.
  logic [HRV_W-1:0]  window_mem [WIN_DEPTH];
  logic [WIN_AW-1:0] window_slot;
  logic [SUM_W-1:0]  window_total;
  logic [HRV_W-1:0]  prev_hrv;
  logic [GAIN_W-1:0] gain;
  logic [TIME_W-1:0] last_sample_ms;
  logic [TIME_W-1:0] last_refresh_ms;

  levels_t expected_levels [$];
  int      mismatches  = 0;
  int      outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  // Take a sample into the window and update the gain when it strays from the average.
  task automatic take_sample(input logic [TIME_W-1:0] t, input logic [HRV_W-1:0] h);
    logic [63:0] scaled;
    logic [63:0] dev;
    logic [63:0] ratio;
    window_total = window_total - window_mem[window_slot] + h;
    window_mem[window_slot] = h;
    window_slot = window_slot + 1'b1;
    if (window_total != 0) begin
      scaled = 64'(h) * WIN_DEPTH;
      dev = (scaled > 64'(window_total)) ? scaled - 64'(window_total)
                                         : 64'(window_total) - scaled;
      if ((dev << 16) > 64'(threshold) * 64'(window_total) && prev_hrv != 0) begin
        ratio = (64'(h) * 64'd4096) / 64'(prev_hrv);
        gain = (ratio > 64'd65535) ? 16'hFFFF : ratio[15:0];
      end
    end
    prev_hrv = h;
    last_sample_ms = t;
  endtask

  // Work out what one input transaction does and queue the levels it should produce.
  task automatic predict_levels(input logic [TIME_W-1:0] t, input logic [HRV_W-1:0] h);
    logic [TIME_W-1:0] elapsed;
    int      ms;
    int      span;
    longint  scaled_level;
    int      g;
    int      c;
    levels_t lv;
    elapsed = t - last_sample_ms;
    if (elapsed > {16'd0, interval_ms}) take_sample(t, h);
    elapsed = t - last_refresh_ms;
    if (elapsed < 32'd20) return;
    last_refresh_ms = t;
    // Inverted linear map of the clamped whole-ms sample.
    ms = int'(h[HRV_W-1:HRV_FRAC]);
    if (ms < 20) ms = 20;
    if (ms > 200) ms = 200;
    span = (ms - 20) * (int'(floor_level) - int'(top_level));
    scaled_level = longint'(int'(top_level) + span / 180) * longint'(gain);
    g = int'(scaled_level >>> 12);
    if (g < int'(floor_level)) g = int'(floor_level);
    else if (g > int'(top_level)) g = int'(top_level);
    c = (g * int'(centre_mult)) >>> 6;
    if (c > 255) c = 255;
    lv.ring = g[7:0];
    lv.center = c[7:0];
    expected_levels.push_back(lv);
  endtask

  always @(posedge clk) begin
    levels_t want;
    levels_t got;
    if (!rst_n) begin
      interval_ms     = 16'd1000;
      threshold       = 16'd6554;
      top_level       = 8'd255;
      floor_level     = 8'd10;
      centre_mult     = 8'd96;
      foreach (window_mem[i]) window_mem[i] = '0;
      window_slot     = '0;
      window_total    = '0;
      prev_hrv        = '0;
      gain            = GAIN_ONE;
      last_sample_ms  = '0;
      last_refresh_ms = '0;
      expected_levels.delete();
    end else begin
      // Configuration writes.
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_UPDATE_INTERVAL: interval_ms = cfg_wdata;
          REG_CHANGE_THRESH:   threshold   = cfg_wdata;
          REG_MAX_LEVEL:       top_level   = cfg_wdata[LVL_W-1:0];
          REG_BASE_LEVEL:      floor_level = cfg_wdata[LVL_W-1:0];
          REG_CENTER_GAIN:     centre_mult = cfg_wdata[LVL_W-1:0];
          default: ;
        endcase
      end
      // Accepted input transaction.
      if (in_tvalid && in_tready)
        predict_levels(in_tdata[TIME_W-1:0], in_tdata[TIME_W+HRV_W-1:TIME_W]);
      // Accepted output transaction.
      if (out_tvalid && out_tready) begin
        got = out_tdata[2*LVL_W-1:0];
        if (expected_levels.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: ring %0d center %0d", $time, got.ring, got.center);
        end else begin
          want = expected_levels.pop_front();
          if (got.ring !== want.ring) begin
            mismatches++;
            $display("%0t: ring_level mismatch: expected %0d, actual %0d",
                     $time, want.ring, got.ring);
          end
          if (got.center !== want.center) begin
            mismatches++;
            $display("%0t: center_level mismatch: expected %0d, actual %0d",
                     $time, want.center, got.center);
          end
        end
      end
    end
    outstanding = expected_levels.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the testbench for the HRV LED brightness modulator: clock, reset, stimulus,
// receiver back-pressure, watchdog and verdict. Depends on hrvm_pkg, the block and the checker.
module tb;
  import hrvm_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 150;
  localparam int HOLD_CYCLES = 400;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr   = '0;
  logic [CFG_W-1:0]       cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     fail_count;
  int                     pending;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_ticket = 0;
  int          hold_seen   = 0;
  int          hold_left   = 0;
  int          quiet_cycles = 0;
  logic [31:0] cur_time    = '0;
  logic [15:0] last_hrv    = '0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  hrv_led_brightness_modulator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  hrvm_level_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: random stalls, plus a long hold-off each time one is requested.
  always @(negedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen  <= hold_ticket;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one input transaction; entered and left at a falling edge.
  task automatic send_item(input logic [31:0] t, input logic [15:0] h);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {h, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering, wait until every expected result has arrived, then let the block settle.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write all five registers, one per cycle.
  task automatic write_settings(input logic [15:0] iv, input logic [15:0] thr,
                                input logic [7:0] maxl, input logic [7:0] basel,
                                input logic [7:0] cg);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_UPDATE_INTERVAL;
    cfg_wdata <= iv;
    @(negedge clk);
    cfg_addr  <= REG_CHANGE_THRESH;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_addr  <= REG_MAX_LEVEL;
    cfg_wdata <= {8'd0, maxl};
    @(negedge clk);
    cfg_addr  <= REG_BASE_LEVEL;
    cfg_wdata <= {8'd0, basel};
    @(negedge clk);
    cfg_addr  <= REG_CENTER_GAIN;
    cfg_wdata <= {8'd0, cg};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One random transaction: time steps around the refresh period and the interval,
  // with occasional jumps; samples mostly in the mapped range, some near the last one.
  task automatic send_random(input int iv);
    int pick;
    logic [15:0] h;
    pick = $urandom_range(0, 99);
    if (pick < 40) cur_time = cur_time + $urandom_range(0, 25);
    else if (pick < 70) cur_time = cur_time + iv + $urandom_range(0, 4) - 2;
    else if (pick < 92) cur_time = cur_time + $urandom_range(0, 3 * iv + 60);
    else cur_time = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 65) h = 16'($urandom_range(160, 3520));
    else if (pick < 85) h = 16'(last_hrv + $urandom_range(0, 64) - 32);
    else h = 16'($urandom());
    last_hrv = h;
    send_item(cur_time, h);
  endtask

  // A random phase with its idle rates, one long receiver hold and one full drain pause.
  task automatic run_phase(input int n, input int tx, input int rx, input int iv);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) hold_ticket++;
      if (i == (2 * n) / 3) wait_drain();
      send_random(iv);
    end
  endtask

  initial begin
    int iv;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part with reset settings: refresh edge, first sample with no previous one,
    // interval edge, gain ratio and its saturation, zero gain, time wrap.
    send_item(32'd5, 16'h0000);
    send_item(32'd20, 16'h0000);
    send_item(32'd1001, 16'd1600);
    send_item(32'd2001, 16'd1600);
    send_item(32'd2002, 16'd3200);
    send_item(32'd2010, 16'd800);
    send_item(32'd3003, 16'hFFFF);
    send_item(32'd4004, 16'h0001);
    send_item(32'd5005, 16'h0000);
    send_item(32'd6006, 16'd800);
    send_item(32'hFFFF_FFF0, 16'd2400);
    send_item(32'h0000_0010, 16'hAAAA);
    send_item(32'hFFFF_FFFF, 16'h5555);
    wait_drain();

    // Zero interval and threshold, inverted clamp bounds, full centre gain.
    write_settings(16'd0, 16'd0, 8'd0, 8'd255, 8'd255);
    send_item(32'd7000, 16'd1000);
    send_item(32'd7000, 16'd2000);
    send_item(32'd7030, 16'd400);
    send_item(32'd7060, 16'd3300);
    send_item(32'd7061, 16'd320);
    wait_drain();

    // Largest interval and threshold, widest level range, zero centre gain.
    write_settings(16'hFFFF, 16'hFFFF, 8'd255, 8'd0, 8'd0);
    send_item(32'd7100, 16'd1200);
    send_item(32'd72636, 16'd2900);
    send_item(32'd138171, 16'd500);
    send_item(32'd138172, 16'd3100);
    send_item(32'd138200, 16'hFFFF);
    wait_drain();

    // Random phases: sender idles little and receiver much, then the reverse, then no idling.
    cur_time = 32'd200000;
    iv = $urandom_range(0, 1500);
    write_settings(16'(iv), 16'($urandom_range(0, 20000)), 8'($urandom_range(128, 255)),
                   8'($urandom_range(0, 100)), 8'($urandom()));
    run_phase(630, 21, 70, iv);
    wait_drain();

    iv = $urandom_range(0, 40);
    write_settings(16'(iv), 16'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
    run_phase(630, 70, 21, iv);
    wait_drain();

    iv = $urandom_range(0, 65535);
    write_settings(16'(iv), 16'($urandom_range(0, 13000)), 8'($urandom_range(100, 255)),
                   8'($urandom_range(0, 60)), 8'($urandom_range(32, 160)));
    run_phase(630, 0, 0, iv);
    wait_drain();

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
